// ----- design/dfs_choice_stack_with_steal_defines.svh -----
// Assertion macros shared by the choice stack RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef DFS_CHOICE_STACK_WITH_STEAL_DEFINES_SVH
`define DFS_CHOICE_STACK_WITH_STEAL_DEFINES_SVH
// Checks that a condition implies a consequence in the same cycle.
`define DCS_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);
`endif

// ----- design/dcs_pkg.sv -----
// Types and constants of the choice stack block.
// Depends on nothing; used by all modules of the block.
package dcs_pkg;
	localparam int MAX_DEPTH_DEF = 64;

	localparam logic [2:0] MODE_CLEAR   = 3'd0;
	localparam logic [2:0] MODE_APPEND  = 3'd1;
	localparam logic [2:0] MODE_GET     = 3'd2;
	localparam logic [2:0] MODE_ADVANCE = 3'd3;
	localparam logic [2:0] MODE_STEAL   = 3'd4;
	localparam logic [2:0] MODE_READ    = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_STEAL  = 3'd1;
	localparam logic [2:0] ST_HEIGHT    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_LOCKED    = 3'd5;

	typedef enum logic [2:0] {
		OP_CLEAR, OP_APPEND, OP_GET, OP_ADVANCE, OP_STEAL, OP_READ, OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] height;
		logic [7:0] option_count;
		logic [7:0] prefix_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] choice_value;
		logic       last_item;
		logic [2:0] status;
		logic       search_finished;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] height;
		logic [7:0] option_count;
		logic [7:0] prefix_value;
	} cmd_t;
endpackage

// ----- design/dfs_choice_stack_with_steal.sv -----
// Top level of the depth-first choice stack with work stealing.
// Depends on dcs_pkg, dcs_front and dcs_back.
//
// Requests enter through a queue port: an item is taken when push is high and
// full is low. Results leave through a queue port: the oldest result is shown
// while empty is low and is taken when pop is high. Every request gives one or
// more results, the final one marked by last_item.
// The front decodes requests into a two-entry command queue, so new requests
// are taken while the back is busy. The back runs one command at a time.
// Clear, append and unused modes go straight to S_EMIT; a get choice that
// reads memory waits in S_GET_WAIT. Advance runs S_ADV_RD and S_ADV_EVAL per
// level examined, steal S_STL_RD and S_STL_EVAL per level scanned, and steal
// and read then S_PATH_RD and S_PATH_EMIT per path element from pmem and cmem.
// Reset empties the path and the search flag; memories keep no reset.
// When the receiver stalls, one result waits in the output register and the
// back holds; the command queue keeps taking requests until it is full.
module dfs_choice_stack_with_steal #(
	parameter int MAX_DEPTH = dcs_pkg::MAX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  dcs_pkg::in_item_t  request,
	output logic               empty,
	input  logic               pop,
	output dcs_pkg::out_item_t result
);
	logic          cmd_valid, cmd_ready;
	dcs_pkg::cmd_t cmd;

	dcs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	dcs_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .empty(empty), .pop(pop), .result(result)
	);
endmodule

// ----- design/dcs_front.sv -----
// Front part: accepts input items, decodes them and queues them.
// Depends on dcs_pkg.
module dcs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  dcs_pkg::in_item_t request,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output dcs_pkg::cmd_t    cmd
);
	dcs_pkg::cmd_t fifo_q [2];
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	dcs_pkg::cmd_t dec;
	logic do_push, do_pop;

	always_comb begin
		dec.height = request.height;
		dec.prefix_value = request.prefix_value;
		dec.option_count = (request.option_count == 8'd0) ? 8'd1 : request.option_count;
		unique case (request.mode)
			dcs_pkg::MODE_CLEAR:   dec.op = dcs_pkg::OP_CLEAR;
			dcs_pkg::MODE_APPEND:  dec.op = dcs_pkg::OP_APPEND;
			dcs_pkg::MODE_GET:     dec.op = dcs_pkg::OP_GET;
			dcs_pkg::MODE_ADVANCE: dec.op = dcs_pkg::OP_ADVANCE;
			dcs_pkg::MODE_STEAL:   dec.op = dcs_pkg::OP_STEAL;
			dcs_pkg::MODE_READ:    dec.op = dcs_pkg::OP_READ;
			default:               dec.op = dcs_pkg::OP_NOP;
		endcase
	end

	assign full = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = fifo_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

// ----- design/dcs_back.sv -----
// Back part: prefix, choice and level memories, operation sequencer, result register.
// Depends on dcs_pkg and dfs_choice_stack_with_steal_defines.svh.
`include "dfs_choice_stack_with_steal_defines.svh"
module dcs_back #(
	parameter int MAX_DEPTH = dcs_pkg::MAX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dcs_pkg::cmd_t      cmd,
	output logic               empty,
	input  logic               pop,
	output dcs_pkg::out_item_t result
);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int EW = ((CW > 8) ? CW : 8) + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_GET_WAIT, S_ADV_RD, S_ADV_EVAL, S_STL_RD, S_STL_EVAL,
		S_PATH_RD, S_PATH_EMIT, S_EMIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] plen_q, lcnt_q, idx_q, lvl_end_q;
	logic done_q, src_pfx_q, steal_q;
	logic [7:0] stolen_q;
	dcs_pkg::out_item_t res_q, out_q, out_data, res_idle;
	logic out_valid_q, out_load, can_emit;

	logic [7:0] pmem [MAX_DEPTH];
	logic [7:0] cmem [MAX_DEPTH];
	logic [7:0] nmem [MAX_DEPTH];
	logic [7:0] lmem [MAX_DEPTH];
	logic [7:0] p_rd, c_rd, n_rd, l_rd;
	logic p_re, c_re, l_re, p_we, c_we, n_we, l_we;
	logic [AW-1:0] p_ra, c_ra, l_ra, p_wa, c_wa, l_wa;
	logic [7:0] p_wd, c_wd, n_wd, l_wd;

	logic [EW-1:0] h_e, plen_e, lcnt_e, rel_e;
	logic [SW-1:0] sum_s, total_s;
	logic depth_full, path_last, idx_in_pfx;
	logic [CW-1:0] lcnt_m1, idx_rel;

	assign h_e = EW'(cmd.height);
	assign plen_e = EW'(plen_q);
	assign lcnt_e = EW'(lcnt_q);
	assign rel_e = h_e - plen_e;
	assign sum_s = SW'(plen_q) + SW'(lcnt_q);
	assign total_s = SW'(plen_q) + SW'(lvl_end_q);
	assign depth_full = (sum_s >= SW'(MAX_DEPTH));
	assign lcnt_m1 = lcnt_q - CW'(1);
	assign idx_rel = idx_q - plen_q;
	assign idx_in_pfx = (idx_q < plen_q);
	assign path_last = !steal_q && (SW'(idx_q) + SW'(1) == total_s);
	assign can_emit = !out_valid_q || pop;
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		res_idle = '{choice_value: 8'd0, last_item: 1'b1,
			status: dcs_pkg::ST_OK, search_finished: done_q};
		unique case (cmd.op)
			dcs_pkg::OP_CLEAR: begin
				res_idle.search_finished = 1'b0;
			end
			dcs_pkg::OP_APPEND: begin
				if (lcnt_q != '0) begin
					res_idle.status = dcs_pkg::ST_LOCKED;
				end else if (depth_full) begin
					res_idle.status = dcs_pkg::ST_FULL;
				end else begin
					res_idle.choice_value = cmd.prefix_value;
				end
			end
			dcs_pkg::OP_GET: begin
				if (h_e < plen_e || rel_e < lcnt_e) begin
				end else if (rel_e > lcnt_e) begin
					res_idle.status = dcs_pkg::ST_HEIGHT;
				end else if (depth_full) begin
					res_idle.status = dcs_pkg::ST_FULL;
				end
			end
			dcs_pkg::OP_STEAL: begin
				if (done_q) begin
					res_idle.status = dcs_pkg::ST_NO_STEAL;
				end
			end
			dcs_pkg::OP_READ: begin
				if (sum_s == '0) begin
					res_idle.status = dcs_pkg::ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		p_re = 1'b0; c_re = 1'b0; l_re = 1'b0;
		p_we = 1'b0; c_we = 1'b0; n_we = 1'b0; l_we = 1'b0;
		p_ra = '0; c_ra = '0; l_ra = '0; p_wa = '0; c_wa = '0; l_wa = '0;
		p_wd = cmd.prefix_value; c_wd = 8'd0; n_wd = 8'd1; l_wd = cmd.option_count;
		out_load = 1'b0;
		out_data = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == dcs_pkg::OP_APPEND && lcnt_q == '0 && !depth_full) begin
						p_we = 1'b1;
						p_wa = plen_q[AW-1:0];
					end
					if (cmd.op == dcs_pkg::OP_GET) begin
						if (h_e < plen_e) begin
							p_re = 1'b1;
							p_ra = cmd.height[AW-1:0];
						end else if (rel_e < lcnt_e) begin
							c_re = 1'b1;
							c_ra = rel_e[AW-1:0];
						end else if (rel_e == lcnt_e && !depth_full) begin
							c_we = 1'b1; n_we = 1'b1; l_we = 1'b1;
							c_wa = lcnt_q[AW-1:0];
						end
					end
				end
			end
			S_ADV_RD: begin
				l_re = (lcnt_q != '0);
				l_ra = lcnt_m1[AW-1:0];
			end
			S_ADV_EVAL: begin
				if (n_rd < l_rd) begin
					c_we = 1'b1; n_we = 1'b1;
					c_wa = lcnt_m1[AW-1:0];
					c_wd = n_rd;
					n_wd = n_rd + 8'd1;
				end
			end
			S_STL_RD: begin
				l_re = (idx_q != lcnt_q);
				l_ra = idx_q[AW-1:0];
			end
			S_STL_EVAL: begin
				if (n_rd < l_rd) begin
					n_we = 1'b1;
					c_wa = idx_q[AW-1:0];
					n_wd = n_rd + 8'd1;
				end
			end
			S_PATH_RD: begin
				if (SW'(idx_q) != total_s) begin
					if (idx_in_pfx) begin
						p_re = 1'b1;
						p_ra = idx_q[AW-1:0];
					end else begin
						c_re = 1'b1;
						c_ra = idx_rel[AW-1:0];
					end
				end
			end
			S_PATH_EMIT: begin
				out_load = can_emit;
				out_data.choice_value = src_pfx_q ? p_rd : c_rd;
				out_data.last_item = path_last;
				out_data.status = dcs_pkg::ST_OK;
				out_data.search_finished = done_q;
			end
			S_EMIT: begin
				out_load = can_emit;
			end
			default: begin
			end
		endcase
		l_wa = c_wa;
	end

	always_ff @(posedge clk) begin
		if (p_we) pmem[p_wa] <= p_wd;
		if (c_we) cmem[c_wa] <= c_wd;
		if (n_we) nmem[l_wa] <= n_wd;
		if (l_we) lmem[l_wa] <= l_wd;
		if (p_re) p_rd <= pmem[p_ra];
		if (c_re) c_rd <= cmem[c_ra];
		if (l_re) begin
			n_rd <= nmem[l_ra];
			l_rd <= lmem[l_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_data;
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plen_q <= '0;
			lcnt_q <= '0;
			done_q <= 1'b0;
			idx_q <= '0;
			lvl_end_q <= '0;
			src_pfx_q <= 1'b0;
			steal_q <= 1'b0;
			stolen_q <= 8'd0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_q <= res_idle;
						unique case (cmd.op)
							dcs_pkg::OP_CLEAR: begin
								plen_q <= '0;
								lcnt_q <= '0;
								done_q <= 1'b0;
								state_q <= S_EMIT;
							end
							dcs_pkg::OP_APPEND: begin
								if (lcnt_q == '0 && !depth_full) begin
									plen_q <= plen_q + CW'(1);
								end
								state_q <= S_EMIT;
							end
							dcs_pkg::OP_GET: begin
								if (h_e < plen_e) begin
									src_pfx_q <= 1'b1;
									state_q <= S_GET_WAIT;
								end else if (rel_e < lcnt_e) begin
									src_pfx_q <= 1'b0;
									state_q <= S_GET_WAIT;
								end else begin
									if (rel_e == lcnt_e && !depth_full) begin
										lcnt_q <= lcnt_q + CW'(1);
									end
									state_q <= S_EMIT;
								end
							end
							dcs_pkg::OP_ADVANCE: begin
								state_q <= S_ADV_RD;
							end
							dcs_pkg::OP_STEAL: begin
								if (done_q) begin
									state_q <= S_EMIT;
								end else begin
									idx_q <= '0;
									state_q <= S_STL_RD;
								end
							end
							dcs_pkg::OP_READ: begin
								if (sum_s == '0) begin
									state_q <= S_EMIT;
								end else begin
									lvl_end_q <= lcnt_q;
									steal_q <= 1'b0;
									idx_q <= '0;
									state_q <= S_PATH_RD;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_GET_WAIT: begin
					res_q.choice_value <= src_pfx_q ? p_rd : c_rd;
					state_q <= S_EMIT;
				end
				S_ADV_RD: begin
					if (lcnt_q == '0) begin
						done_q <= 1'b1;
						res_q.search_finished <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ADV_EVAL;
					end
				end
				S_ADV_EVAL: begin
					if (n_rd < l_rd) begin
						res_q.choice_value <= n_rd;
						state_q <= S_EMIT;
					end else begin
						lcnt_q <= lcnt_m1;
						state_q <= S_ADV_RD;
					end
				end
				S_STL_RD: begin
					if (idx_q == lcnt_q) begin
						res_q.status <= dcs_pkg::ST_NO_STEAL;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_STL_EVAL;
					end
				end
				S_STL_EVAL: begin
					if (n_rd < l_rd) begin
						stolen_q <= n_rd;
						lvl_end_q <= idx_q;
						steal_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_PATH_RD;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_STL_RD;
					end
				end
				S_PATH_RD: begin
					if (SW'(idx_q) == total_s) begin
						res_q.choice_value <= stolen_q;
						state_q <= S_EMIT;
					end else begin
						src_pfx_q <= idx_in_pfx;
						state_q <= S_PATH_EMIT;
					end
				end
				S_PATH_EMIT: begin
					if (can_emit) begin
						idx_q <= idx_q + CW'(1);
						state_q <= path_last ? S_IDLE : S_PATH_RD;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DCS_ASSERT_NOW(a_depth_bound, clk, arst_n, 1'b1, sum_s <= SW'(MAX_DEPTH), "path exceeds depth")
	`DCS_ASSERT_NOW(a_err_single, clk, arst_n, out_valid_q && out_q.status != dcs_pkg::ST_OK, out_q.last_item, "error result not final")
	`DCS_ASSERT_NEXT(a_done_empty, clk, arst_n, state_q == S_ADV_RD && lcnt_q == '0, done_q && lcnt_q == '0, "finished with open levels")
endmodule
